// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Opcode and status codes, word structs and controller/datapath links.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int OCC_W     = 5;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_POP_FRONT  = 2'd1,
        OP_PUSH_REAR  = 2'd2,
        OP_POP_REAR   = 2'd3
    } deq_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } deq_status_t;

    typedef struct packed {
        deq_op_t                  opcode;
        logic signed [DATA_W-1:0] value;
    } deq_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        deq_status_t              status;
        logic [OCC_W-1:0]         occupancy;
    } deq_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;     // execute the accepted request word
        logic capture;  // load RAM read data into the response register
    } deq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rd_pending;  // request is a removal that reads the RAM
    } deq_sts_t;

endpackage

// ===== rtl/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue of 32-bit values
// Ring buffer with head pointer and element count, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_word) takes one word per operation:
//   opcode selects insert front, remove front, insert rear or remove rear.
//   rsp channel (rsp_valid/rsp_ready/rsp_word) returns exactly one word per
//   request: removed value (zero unless a removal succeeded), status (ok,
//   overflow on insert while full, underflow on remove while empty) and the
//   element count after the operation, masked to 5 bits.
// Timing:
//   inserts and rejected operations: response valid in the cycle after
//   accept, one word per cycle when not stalled.  Successful removals go
//   via S_READ for the registered slot RAM read; req_ready is low there.
//   A new request is taken while the previous response is being drained.
// Reset:
//   rst_n clears head and count, leaving the queue empty; slot contents
//   are not cleared and are only read after being written.
// Stall:
//   the response register holds its word until rsp_ready; meanwhile
//   req_ready stays low, so no request is lost.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  deq_req_t req_word,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output deq_rsp_t rsp_word
);

    deq_cmd_t cmd;
    deq_sts_t sts;

    // controller: handshakes and read sequencing
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: pointers, slot RAM and response register
    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_word (req_word),
        .cmd      (cmd),
        .sts      (sts),
        .rsp_word (rsp_word)
    );

endmodule

// ===== rtl/deq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/deq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl: handshake controller for the double-ended queue
// Sequences request words and owns the response valid flag.
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  deq_sts_t  sts,
    output deq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // response slot is free now or drains at this edge
    assign req_ready   = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign cmd.exec    = req_valid && req_ready;
    assign cmd.capture = (state_reg == S_READ);
    assign rsp_valid   = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.exec)
                begin
                    if (sts.rd_pending)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                state_next     = S_IDLE;
                rsp_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== rtl/deq_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_dpath: ring buffer datapath for the double-ended queue
// Head pointer, element count, slot RAM and response register.
// ----------------------------------------------------------------------------
module deq_dpath
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  deq_req_t  req_word,
    input  deq_cmd_t  cmd,
    output deq_sts_t  sts,
    output deq_rsp_t  rsp_word
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] WRAP     = SW'(DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    deq_rsp_t      rsp_reg;

    logic          is_push, is_front, full, empty, push_ok, pop_ok;
    logic [SW-1:0] tail_sum, last_sum;
    logic [AW-1:0] rear_wr_idx, rear_rd_idx, head_dec, head_inc;
    logic [AW-1:0] waddr, raddr;
    logic          we, re;
    logic [DATA_W-1:0] rdata;
    deq_status_t   status;

    assign is_push  = (req_word.opcode == OP_PUSH_FRONT) || (req_word.opcode == OP_PUSH_REAR);
    assign is_front = (req_word.opcode == OP_PUSH_FRONT) || (req_word.opcode == OP_POP_FRONT);
    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign push_ok  = is_push && !full;
    assign pop_ok   = !is_push && !empty;

    // head + count stays below 2*DEPTH: one conditional subtract wraps it
    assign tail_sum    = SW'(head_reg) + SW'(count_reg);
    assign last_sum    = tail_sum - SW'(1);
    assign rear_wr_idx = (tail_sum >= WRAP) ? AW'(tail_sum - WRAP) : AW'(tail_sum);
    assign rear_rd_idx = (last_sum >= WRAP) ? AW'(last_sum - WRAP) : AW'(last_sum);
    assign head_dec    = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
    assign head_inc    = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);

    assign waddr = is_front ? head_dec : rear_wr_idx;
    assign raddr = is_front ? head_reg : rear_rd_idx;
    assign we    = cmd.exec && push_ok;
    assign re    = cmd.exec && pop_ok;

    assign sts.rd_pending = pop_ok;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        status     = ST_OK;
        if (is_push)
        begin
            if (full)
            begin
                status = ST_OVERFLOW;
            end
            else
            begin
                count_next = count_reg + CW'(1);
                if (is_front)
                begin
                    head_next = head_dec;
                end
            end
        end
        else
        begin
            if (empty)
            begin
                status = ST_UNDERFLOW;
            end
            else
            begin
                count_next = count_reg - CW'(1);
                if (is_front)
                begin
                    head_next = head_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // removal data arrives from the RAM in the cycle after the request executes
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_reg.removed_value <= '0;
            rsp_reg.status        <= status;
            rsp_reg.occupancy     <= OCC_W'(count_next);
        end
        else if (cmd.capture)
        begin
            rsp_reg.removed_value <= rdata;
        end
    end

    assign rsp_word = rsp_reg;

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (req_word.value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule

// ===== rtl/deq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for the double-ended queue
// Response consistency and hold-while-stalled, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input deq_rsp_t rsp_word
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("response changed while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status != ST_OK) |-> rsp_word.removed_value == '0)
        else $error("rejected operation returned data");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status == ST_UNDERFLOW) |-> rsp_word.occupancy == '0)
        else $error("underflow with nonzero occupancy");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status == ST_OVERFLOW) |-> rsp_word.occupancy == FULL_OCC)
        else $error("overflow without full occupancy");

    // a request is never taken while the previous response is stuck
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
        else $error("request accepted while response stalled");

endmodule

bind double_ended_queue_unit deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

// ===== test/deq_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_check_pkg: scoreboard for the double-ended queue testbench
// Keeps a shadow copy of the queue contents, works out the response word
// for each accepted request and checks returned words in order.
// ----------------------------------------------------------------------------
package deq_check_pkg;

    import deq_pkg::*;

    class deque_mirror;

        logic signed [DATA_W-1:0] contents[$];   // front is index 0
        deq_rsp_t                 expected_replies[$];
        int                       errors = 0;

        // Apply one accepted request to the shadow queue, queue its reply.
        function void note_request(deq_req_t w);
            deq_rsp_t r;
            r        = '0;
            r.status = ST_OK;
            case (w.opcode)
                OP_PUSH_FRONT, OP_PUSH_REAR:
                begin
                    if (contents.size() >= DEPTH_DEF)
                        r.status = ST_OVERFLOW;
                    else if (w.opcode == OP_PUSH_FRONT)
                        contents.push_front(w.value);
                    else
                        contents.push_back(w.value);
                end
                default:
                begin
                    if (contents.size() == 0)
                        r.status = ST_UNDERFLOW;
                    else if (w.opcode == OP_POP_FRONT)
                        r.removed_value = contents.pop_front();
                    else
                        r.removed_value = contents.pop_back();
                end
            endcase
            r.occupancy = OCC_W'(contents.size());
            expected_replies.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Compare a returned word against the oldest outstanding reply.
        task check_reply(deq_rsp_t got);
            deq_rsp_t want;
            if (expected_replies.size() == 0)
            begin
                report($sformatf("unexpected response word %h", got));
                return;
            end
            want = expected_replies.pop_front();
            if (got.removed_value !== want.removed_value)
                report($sformatf("removed_value got %0d expected %0d",
                                 got.removed_value, want.removed_value));
            if (got.status !== want.status)
                report($sformatf("status got %0d expected %0d",
                                 got.status, want.status));
            if (got.occupancy !== want.occupancy)
                report($sformatf("occupancy got %0d expected %0d",
                                 got.occupancy, want.occupancy));
        endtask

        function int pending();
            return expected_replies.size();
        endfunction

    endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for double_ended_queue_unit
// Directed corner words, then biased random push/pop traffic with random
// gaps and stalls on both channels; every response word is checked against
// a shadow deque kept by the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    import deq_pkg::*;
    import deq_check_pkg::*;

    localparam int NUM_RANDOM = 500;
    localparam int LONG_HOLD  = 120;   // receiver hold-off, long enough to back up
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    deq_req_t req_word  = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    deq_rsp_t rsp_word;

    deque_mirror mirror = new();

    // Shared knobs between the sender and the receiver process.
    bit quiet      = 1'b0;   // both sides run without idle cycles
    int hold_cycles = 0;     // one-shot long stall request for the receiver

    double_ended_queue_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the DUT hangs on either handshake.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    // Extreme values show up often; the rest is full-range random.
    function automatic logic signed [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request word after an idle gap and hold it until accepted.
    // Valid stays high afterwards so back-to-back words need no re-raise.
    task automatic send_word(input deq_op_t op, input logic signed [DATA_W-1:0] val,
                             input int gap);
        deq_req_t w;
        w.opcode = op;
        w.value  = val;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        mirror.note_request(w);
    endtask

    // Sender goes idle until every outstanding response has been returned.
    task automatic drain_queue();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (mirror.pending() != 0);
    endtask

    // Receiver: one random stall per response word; a pending long hold
    // replaces the draw once.
    initial
    begin : receiver
        int stall;
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (hold_cycles > 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
        end
    end

    // Response monitor: values sampled at the edge are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            mirror.check_reply(rsp_word);
    end

    initial
    begin : stimulus
        int      sent;
        int      seg;
        int      seg_len;
        int      push_pct;
        deq_op_t op;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: underflow on both ends, extremes in and out of both ends,
        // alternating bit patterns, then underflow again after emptying.
        send_word(OP_POP_FRONT,  '0,            draw_gap());
        send_word(OP_POP_REAR,   VAL_MAX,       draw_gap());
        send_word(OP_PUSH_FRONT, VAL_MIN,       draw_gap());
        send_word(OP_PUSH_REAR,  VAL_MAX,       draw_gap());
        send_word(OP_PUSH_FRONT, '1,            draw_gap());
        send_word(OP_PUSH_REAR,  '0,            draw_gap());
        send_word(OP_PUSH_FRONT, 32'sd1,        draw_gap());
        send_word(OP_POP_REAR,   VAL_MIN,       draw_gap());
        send_word(OP_POP_FRONT,  '1,            draw_gap());
        send_word(OP_POP_REAR,   '0,            draw_gap());
        send_word(OP_POP_FRONT,  '0,            draw_gap());
        send_word(OP_POP_FRONT,  '0,            draw_gap());
        send_word(OP_POP_REAR,   '0,            draw_gap());
        send_word(OP_PUSH_REAR,  32'h5555_5555, draw_gap());
        send_word(OP_PUSH_FRONT, 32'hAAAA_AAAA, draw_gap());
        send_word(OP_POP_FRONT,  '0,            draw_gap());
        send_word(OP_POP_FRONT,  '0,            draw_gap());
        send_word(OP_POP_FRONT,  '0,            draw_gap());
        drain_queue();

        // Random: segments biased toward filling, mixing or emptying so the
        // ring wraps and both full and empty are hit many times.
        sent = 0;
        seg  = 0;
        while (sent < NUM_RANDOM)
        begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 15;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            // Once: receiver stalls for a long stretch while words keep coming.
            if (seg == 1)
                hold_cycles = LONG_HOLD;
            for (int i = 0; i < seg_len && sent < NUM_RANDOM; i++)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
                send_word(op, draw_value(), draw_gap());
                sent++;
            end
            // Sender pause until all responses are back: forced once, then
            // at random segment boundaries.
            if (seg == 2 || $urandom_range(0, 2) == 0)
                drain_queue();
            seg++;
        end

        quiet = 1'b0;
        drain_queue();
        repeat (4) @(posedge clk);

        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/deq_dpath.sv
rtl/double_ended_queue_unit.sv
rtl/deq_checker.sv
test/deq_check_pkg.sv
test/tb_top.sv
